>>> hdl/ows_pkg.sv
// Shared types and constants for the one-wire backlight level sender.
// Holds request, segment and command structs and the sequencer state enum.
// No dependencies.
package ows_pkg;

	// Field widths fixed by the line protocol.
	localparam int unsigned LEVEL_W = 6;
	localparam int unsigned DUR_W   = 17;
	localparam int unsigned ADDR_W  = 8;
	localparam int unsigned PULSE_W = 10;
	localparam int unsigned CFG_IDX_W  = 2;
	localparam int unsigned CFG_DATA_W = 10;
	localparam int unsigned DATA_W  = 5;
	localparam int unsigned CNT_W   = 5;

	// Register indexes on the configuration port.
	localparam logic [CFG_IDX_W-1:0] CFG_DEVICE_ADDRESS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SHORT_TIME     = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_LONG_TIME      = 2'd2;

	// Register reset values.
	localparam logic [ADDR_W-1:0]  RST_DEVICE_ADDRESS = 8'h72;
	localparam logic [PULSE_W-1:0] RST_SHORT_TIME     = 10'd10;
	localparam logic [PULSE_W-1:0] RST_LONG_TIME      = 10'd180;

	// Level handling.
	localparam logic [LEVEL_W-1:0] MAX_LEVEL = 6'd32;

	// Fixed segment lengths in microseconds.
	localparam logic [DUR_W-1:0] OFF_LOW_US   = 17'd3000;
	localparam logic [DUR_W-1:0] PRE_LOW_US   = 17'd100000;
	localparam logic [DUR_W-1:0] SEL_HIGH1_US = 17'd120;
	localparam logic [DUR_W-1:0] SEL_LOW_US   = 17'd280;
	localparam logic [DUR_W-1:0] SEL_HIGH2_US = 17'd650;
	localparam logic [DUR_W-1:0] HOLD_US      = 17'd0;

	// Counter values that start and end a phase of the sequencer.
	localparam logic [CNT_W-1:0] PRE_LAST   = 5'd3;
	localparam logic [CNT_W-1:0] FRAME_LAST = 5'd17;
	localparam logic [CNT_W-1:0] FRAME_START = 5'd0;

	typedef struct packed {
		logic [LEVEL_W-1:0] level;
		logic               power_on;
	} req_t;

	typedef struct packed {
		logic             line_high;
		logic [DUR_W-1:0] duration;
		logic             last;
	} seg_t;

	typedef struct packed {
		logic [ADDR_W-1:0]  device_address;
		logic [PULSE_W-1:0] short_time;
		logic [PULSE_W-1:0] long_time;
	} cfg_t;

	typedef enum logic [1:0] {
		CMD_OFF,
		CMD_ZERO,
		CMD_SEND
	} cmd_kind_t;

	// Classified request as it waits in the queue.
	typedef struct packed {
		cmd_kind_t         kind;
		logic              preamble;
		logic [DATA_W-1:0] data;
	} cmd_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SINGLE,
		ST_PRE,
		ST_ADDR,
		ST_DATA,
		ST_END
	} state_t;

	// Mode-select preamble segment by position.
	function automatic seg_t pre_seg(input logic [1:0] idx);
		seg_t s;
		s.last = 1'b0;
		case (idx)
			2'd0: begin
				s.line_high = 1'b0;
				s.duration  = PRE_LOW_US;
			end
			2'd1: begin
				s.line_high = 1'b1;
				s.duration  = SEL_HIGH1_US;
			end
			2'd2: begin
				s.line_high = 1'b0;
				s.duration  = SEL_LOW_US;
			end
			default: begin
				s.line_high = 1'b1;
				s.duration  = SEL_HIGH2_US;
			end
		endcase
		return s;
	endfunction

endpackage

>>> hdl/ows_front.sv
// Front end: accepts requests, clamps the level and classifies each one.
// Tracks the mode-selected flag. Depends on ows_pkg.
module ows_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  ows_pkg::req_t req,
	input  logic          q_full,
	output logic          push,
	output ows_pkg::cmd_t push_cmd
);
	import ows_pkg::*;

	logic               mode_selected_q;
	logic [LEVEL_W-1:0] level_c;
	logic [LEVEL_W-1:0] level_m1;

	// The queue decides whether a request can enter.
	assign req_stall = q_full;
	assign push      = req_valid && !q_full;

	// Clamp the level and form the data byte.
	always_comb begin
		level_c  = (req.level > MAX_LEVEL) ? MAX_LEVEL : req.level;
		level_m1 = level_c - LEVEL_W'(1);
	end

	// Classify the request.
	always_comb begin
		push_cmd.preamble = !mode_selected_q;
		push_cmd.data     = level_m1[DATA_W-1:0];
		if (!req.power_on) begin
			push_cmd.kind = CMD_OFF;
		end else if (req.level == '0) begin
			push_cmd.kind = CMD_ZERO;
		end else begin
			push_cmd.kind = CMD_SEND;
		end
	end

	// A zero level drops the mode; a sent level leaves it selected.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_selected_q <= 1'b1;
		end else if (push && req.power_on) begin
			mode_selected_q <= (req.level != '0);
		end
	end

endmodule

>>> hdl/ows_queue.sv
// Short command queue between the front end and the segment sequencer.
// Depth is set by the DEPTH parameter. Depends on ows_pkg.
module ows_queue #(
	parameter int unsigned DEPTH = 2
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  ows_pkg::cmd_t push_cmd,
	output logic          full,
	input  logic          pop,
	output logic          q_valid,
	output ows_pkg::cmd_t q_cmd
);
	import ows_pkg::*;

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W_Q = $clog2(DEPTH + 1);

	cmd_t               entry_q [DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W_Q-1:0] count_q;
	logic               do_push;
	logic               do_pop;

	assign full    = (count_q == CNT_W_Q'(DEPTH));
	assign q_valid = (count_q != '0);
	assign q_cmd   = entry_q[rd_ptr_q];
	assign do_push = push && !full;
	assign do_pop  = pop && q_valid;

	// Entry storage.
	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CNT_W_Q'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CNT_W_Q'(1);
			end
		end
	end

endmodule

>>> hdl/ows_back.sv
// Back end: walks each queued command through its line segments, one per cycle unless seg is stalled.
// Holds the output register toward the segment channel. Depends on ows_pkg.
module ows_back (
	input  logic          clk,
	input  logic          arst_n,
	input  ows_pkg::cfg_t cfg,
	input  logic          q_valid,
	input  ows_pkg::cmd_t q_cmd,
	output logic          pop,
	output logic          seg_valid,
	input  logic          seg_stall,
	output ows_pkg::seg_t seg
);
	import ows_pkg::*;

	state_t             state_q;
	state_t             state_d;
	logic [CNT_W-1:0]   cnt_q;
	logic [CNT_W-1:0]   cnt_d;
	cmd_t               cmd_q;
	logic               out_valid_q;
	seg_t               out_seg_q;
	logic               adv;
	logic               emit;
	seg_t               cur_seg;
	logic [ADDR_W-1:0]  frame_byte;
	logic [CNT_W-1:0]   cnt_m1;
	logic [2:0]         bit_pos;
	logic               bit_val;
	logic [DUR_W-1:0]   short_dur;
	logic [DUR_W-1:0]   long_dur;

	// The output register can take a segment when empty or being drained.
	assign adv  = !out_valid_q || !seg_stall;
	assign emit = (state_q != ST_IDLE) && adv;

	assign short_dur = {{(DUR_W-PULSE_W){1'b0}}, cfg.short_time};
	assign long_dur  = {{(DUR_W-PULSE_W){1'b0}}, cfg.long_time};

	// Bit selection inside a byte frame.
	always_comb begin
		frame_byte = (state_q == ST_ADDR) ? cfg.device_address
		                                  : {{(ADDR_W-DATA_W){1'b0}}, cmd_q.data};
		cnt_m1     = cnt_q - CNT_W'(1);
		bit_pos    = cnt_m1[3:1];
		bit_val    = frame_byte[3'd7 - bit_pos];
	end

	// Next state and segment counter.
	always_comb begin
		state_d = state_q;
		cnt_d   = cnt_q;
		case (state_q)
			ST_IDLE: begin
				cnt_d = '0;
				if (q_valid) begin
					case (q_cmd.kind)
						CMD_SEND: state_d = q_cmd.preamble ? ST_PRE : ST_ADDR;
						default:  state_d = ST_SINGLE;
					endcase
				end
			end
			ST_SINGLE, ST_END: begin
				if (adv) begin
					state_d = ST_IDLE;
				end
			end
			ST_PRE: begin
				if (adv) begin
					if (cnt_q == PRE_LAST) begin
						state_d = ST_ADDR;
						cnt_d   = FRAME_START;
					end else begin
						cnt_d = cnt_q + CNT_W'(1);
					end
				end
			end
			ST_ADDR, ST_DATA: begin
				if (adv) begin
					if (cnt_q == FRAME_LAST) begin
						state_d = (state_q == ST_ADDR) ? ST_DATA : ST_END;
						cnt_d   = FRAME_START;
					end else begin
						cnt_d = cnt_q + CNT_W'(1);
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
				cnt_d   = '0;
			end
		endcase
	end

	// Segment for the current step and the queue pop.
	always_comb begin
		pop     = (state_q == ST_IDLE) && q_valid;
		cur_seg = '0;
		case (state_q)
			ST_SINGLE: begin
				cur_seg.line_high = 1'b0;
				cur_seg.duration  = (cmd_q.kind == CMD_ZERO) ? OFF_LOW_US : HOLD_US;
				cur_seg.last      = 1'b1;
			end
			ST_PRE: begin
				cur_seg = pre_seg(cnt_q[1:0]);
			end
			ST_ADDR, ST_DATA: begin
				cur_seg.last = 1'b0;
				if (cnt_q == FRAME_START) begin
					// Start pulse.
					cur_seg.line_high = 1'b1;
					cur_seg.duration  = short_dur;
				end else if (cnt_q == FRAME_LAST) begin
					// Stop pulse.
					cur_seg.line_high = 1'b0;
					cur_seg.duration  = short_dur;
				end else if (!cnt_m1[0]) begin
					// Low half of a bit: short for a one, long for a zero.
					cur_seg.line_high = 1'b0;
					cur_seg.duration  = bit_val ? short_dur : long_dur;
				end else begin
					// High half of a bit.
					cur_seg.line_high = 1'b1;
					cur_seg.duration  = bit_val ? long_dur : short_dur;
				end
			end
			ST_END: begin
				cur_seg.line_high = 1'b1;
				cur_seg.duration  = HOLD_US;
				cur_seg.last      = 1'b1;
			end
			default: begin
				cur_seg = '0;
			end
		endcase
	end

	// Sequencer control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
		end
	end

	// Command held for the duration of its segments.
	always_ff @(posedge clk) begin
		if (pop) begin
			cmd_q <= q_cmd;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= emit;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_seg_q <= cur_seg;
		end
	end

	assign seg_valid = out_valid_q;
	assign seg       = out_seg_q;

endmodule

>>> hdl/one_wire_backlight_level_sender.sv
// Top level of the one-wire backlight level sender.
// Holds the configuration registers and joins ows_front, ows_queue and ows_back.
// Depends on ows_pkg.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+-------------------------------
//  req     | in        | req_valid/req_stall  | req_t: level, power_on
//  seg     | out       | seg_valid/seg_stall  | seg_t: line_high, duration, last
//  cfg     | in        | cfg_we               | cfg_index, cfg_wdata
//
// A powered request with a nonzero level gives 37 segments, or 41 with the mode-select
// preamble; power off and level zero give one. The back sequencer emits one
// segment per cycle while seg is not stalled and passes through its idle state
// to load each command from the queue.
// Reset restores the register defaults, empties the queue and sets the mode flag.
// Requests keep entering while the queue has room, even while seg is stalled.
module one_wire_backlight_level_sender #(
	parameter int unsigned QUEUE_DEPTH = 2
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               req_valid,
	output logic                               req_stall,
	input  ows_pkg::req_t                      req,
	output logic                               seg_valid,
	input  logic                               seg_stall,
	output ows_pkg::seg_t                      seg,
	input  logic                               cfg_we,
	input  logic [ows_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [ows_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
	import ows_pkg::*;

	cfg_t cfg_q;
	logic q_full;
	logic push;
	cmd_t push_cmd;
	logic pop;
	logic q_valid;
	cmd_t q_cmd;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.device_address <= RST_DEVICE_ADDRESS;
			cfg_q.short_time     <= RST_SHORT_TIME;
			cfg_q.long_time      <= RST_LONG_TIME;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_DEVICE_ADDRESS: cfg_q.device_address <= cfg_wdata[ADDR_W-1:0];
				CFG_SHORT_TIME:     cfg_q.short_time     <= cfg_wdata[PULSE_W-1:0];
				CFG_LONG_TIME:      cfg_q.long_time      <= cfg_wdata[PULSE_W-1:0];
				default: ;
			endcase
		end
	end

	ows_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req      (req),
		.q_full   (q_full),
		.push     (push),
		.push_cmd (push_cmd)
	);

	ows_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.push_cmd(push_cmd),
		.full    (q_full),
		.pop     (pop),
		.q_valid (q_valid),
		.q_cmd   (q_cmd)
	);

	ows_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.q_valid  (q_valid),
		.q_cmd    (q_cmd),
		.pop      (pop),
		.seg_valid(seg_valid),
		.seg_stall(seg_stall),
		.seg      (seg)
	);

	// The sequencer only loads a command that the queue holds.
	a_pop_has_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> q_valid)
		else $error("sequencer popped an empty queue");

	// A final high segment always holds the line.
	a_final_high_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(seg_valid && seg.last && seg.line_high) |-> (seg.duration == HOLD_US))
		else $error("final high segment has a nonzero duration");

	// A zero-length segment before the end needs a zero pulse register.
	a_zero_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		(seg_valid && !seg.last && seg.duration == '0)
		|-> (cfg_q.short_time == '0 || cfg_q.long_time == '0))
		else $error("zero-length segment inside a frame");

	// A full queue holds the request channel off in the next cycle too
	// unless the sequencer drained an entry.
	a_full_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		(q_full && !pop) |=> req_stall)
		else $error("queue lost its full state without a pop");

endmodule

>>> tb/tb_one_wire_backlight_level_sender.sv
// Self-checking testbench for the one-wire backlight level sender.
// Predicts every waveform segment of each request and checks the block's output against it.
// Depends on ows_pkg and the one_wire_backlight_level_sender RTL.
module tb_one_wire_backlight_level_sender;
	timeunit 1ns;
	timeprecision 1ps;

	import ows_pkg::*;

	// Index that selects no register; writes to it must change nothing.
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_INDEX = 2'd3;
	localparam int unsigned RANDOM_REQUESTS = 410;
	localparam int unsigned NUM_SETTINGS    = 9;
	localparam int unsigned DRAIN_LIMIT     = 5000;
	localparam int unsigned SETTLE_CYCLES   = 8;
	localparam int unsigned PRINT_LIMIT     = 50;

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  req_valid = 1'b0;
	logic                  req_stall;
	req_t                  req       = '0;
	logic                  seg_valid;
	logic                  seg_stall = 1'b0;
	seg_t                  seg;
	logic                  cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;

	one_wire_backlight_level_sender DUT (.*);

	// Requests waiting to be driven and segments waiting to be seen.
	req_t bl_requests[$];
	seg_t seg_expected[$];

	// Predictor copy of the registers and the mode-selected flag.
	logic [ADDR_W-1:0]  addr_shadow  = RST_DEVICE_ADDRESS;
	logic [PULSE_W-1:0] short_shadow = RST_SHORT_TIME;
	logic [PULSE_W-1:0] long_shadow  = RST_LONG_TIME;
	logic               mode_shadow  = 1'b1;

	int unsigned req_gap_pct      = 0;
	int unsigned stall_pct        = 0;
	int unsigned req_gap_left     = 0;
	int unsigned stall_left       = 0;
	logic        req_fire         = 1'b0;
	int unsigned error_count      = 0;
	int unsigned requests_taken   = 0;
	int unsigned segments_checked = 0;

	// Clock with a 4 ns period.
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	task automatic report_mismatch(input string msg);
		error_count++;
		if (error_count <= PRINT_LIMIT) begin
			$display("[%0t] ERROR: %s", $realtime, msg);
		end
	endtask

	function automatic void push_segment(input logic high, input logic [DUR_W-1:0] dur,
			input logic fin);
		seg_t s;
		s.line_high = high;
		s.duration  = dur;
		s.last      = fin;
		seg_expected.push_back(s);
	endfunction

	// One byte on the wire: start high, eight bits MSB first, stop low.
	function automatic void push_byte_frame(input logic [7:0] value);
		push_segment(1'b1, DUR_W'(short_shadow), 1'b0);
		for (int b = 7; b >= 0; b--) begin
			if (value[b]) begin
				push_segment(1'b0, DUR_W'(short_shadow), 1'b0);
				push_segment(1'b1, DUR_W'(long_shadow), 1'b0);
			end else begin
				push_segment(1'b0, DUR_W'(long_shadow), 1'b0);
				push_segment(1'b1, DUR_W'(short_shadow), 1'b0);
			end
		end
		push_segment(1'b0, DUR_W'(short_shadow), 1'b0);
	endfunction

	// Expected waveform for one accepted request.
	function automatic void predict_waveform(input req_t r);
		logic [LEVEL_W-1:0] lvl;
		lvl = (r.level > MAX_LEVEL) ? MAX_LEVEL : r.level;
		if (!r.power_on) begin
			push_segment(1'b0, HOLD_US, 1'b1);
		end else if (lvl == '0) begin
			mode_shadow = 1'b0;
			push_segment(1'b0, OFF_LOW_US, 1'b1);
		end else begin
			// Mode-select preamble only when the mode was dropped.
			if (!mode_shadow) begin
				push_segment(1'b0, PRE_LOW_US, 1'b0);
				push_segment(1'b1, SEL_HIGH1_US, 1'b0);
				push_segment(1'b0, SEL_LOW_US, 1'b0);
				push_segment(1'b1, SEL_HIGH2_US, 1'b0);
				mode_shadow = 1'b1;
			end
			push_byte_frame(addr_shadow);
			push_byte_frame({3'b000, DATA_W'(lvl - 6'd1)});
			push_segment(1'b1, HOLD_US, 1'b1);
		end
	endfunction

	task automatic check_segment(input seg_t got);
		seg_t want;
		if (seg_expected.size() == 0) begin
			report_mismatch($sformatf("segment with none expected: high %0d dur %0d last %0d",
				got.line_high, got.duration, got.last));
			return;
		end
		want = seg_expected.pop_front();
		segments_checked++;
		if (got.line_high !== want.line_high) begin
			report_mismatch($sformatf("line_high %0d, expected %0d", got.line_high,
				want.line_high));
		end
		if (got.duration !== want.duration) begin
			report_mismatch($sformatf("duration %0d, expected %0d", got.duration,
				want.duration));
		end
		if (got.last !== want.last) begin
			report_mismatch($sformatf("last %0d, expected %0d", got.last, want.last));
		end
	endtask

	// Sample both handshakes at the rising edge.
	always @(posedge clk) begin
		req_fire <= req_valid && !req_stall;
		if (arst_n && req_valid && !req_stall) begin
			predict_waveform(req);
			requests_taken++;
		end
		if (arst_n && seg_valid && !seg_stall) begin
			check_segment(seg);
		end
	end

	// Request driver: holds a request until taken, with random gaps between requests.
	always @(negedge clk) begin
		if (req_valid && !req_fire) begin
			// Still waiting for the block to take the current request.
		end else if (req_gap_left != 0) begin
			req_gap_left--;
			req_valid <= 1'b0;
		end else if (bl_requests.size() != 0 && req_gap_pct != 0 &&
				$urandom_range(99) < req_gap_pct) begin
			req_gap_left = $urandom_range(4, 1) - 1;
			req_valid <= 1'b0;
		end else if (bl_requests.size() != 0) begin
			req       <= bl_requests.pop_front();
			req_valid <= 1'b1;
		end else begin
			req_valid <= 1'b0;
		end
	end

	// Segment receiver stalls in random bursts.
	always @(negedge clk) begin
		if (stall_left != 0) begin
			stall_left--;
			seg_stall <= 1'b1;
		end else if (stall_pct != 0 && $urandom_range(99) < stall_pct) begin
			stall_left = $urandom_range(4, 1) - 1;
			seg_stall <= 1'b1;
		end else begin
			seg_stall <= 1'b0;
		end
	end

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		case (idx)
			CFG_DEVICE_ADDRESS: addr_shadow = data[ADDR_W-1:0];
			CFG_SHORT_TIME:     short_shadow = data;
			CFG_LONG_TIME:      long_shadow = data;
			default: begin
			end
		endcase
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic queue_request(input logic [LEVEL_W-1:0] level, input logic power_on);
		req_t r;
		r.level    = level;
		r.power_on = power_on;
		bl_requests.push_back(r);
	endtask

	// Mostly powered nonzero levels, with off, zero and clamped levels mixed in.
	task automatic queue_random_request();
		int unsigned pick;
		pick = $urandom_range(99);
		if (pick < 10) begin
			queue_request(LEVEL_W'($urandom_range(63)), 1'b0);
		end else if (pick < 22) begin
			queue_request('0, 1'b1);
		end else if (pick < 30) begin
			queue_request(LEVEL_W'($urandom_range(63, 32)), 1'b1);
		end else begin
			queue_request(LEVEL_W'($urandom_range(63, 1)), 1'b1);
		end
	endtask

	// Wait until every request is taken and every segment has come out.
	task automatic wait_drained();
		int unsigned waited;
		waited = 0;
		while (bl_requests.size() != 0 || req_valid) begin
			@(negedge clk);
		end
		while (seg_expected.size() != 0 && waited < DRAIN_LIMIT) begin
			@(negedge clk);
			waited++;
		end
		if (seg_expected.size() != 0) begin
			report_mismatch($sformatf("%0d expected segments never arrived",
				seg_expected.size()));
			seg_expected.delete();
		end
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// Main sequence: directed requests, then several register settings with random traffic.
	initial begin
		int unsigned per_setting;
		per_setting = RANDOM_REQUESTS / NUM_SETTINGS;
		repeat (12) @(negedge clk);
		arst_n = 1'b1;

		// Directed requests under the reset register values.
		req_gap_pct = 30;
		stall_pct   = 30;
		queue_request(6'd0, 1'b0);
		queue_request(6'd1, 1'b1);
		queue_request(6'd32, 1'b1);
		queue_request(6'd63, 1'b1);
		queue_request(6'd33, 1'b1);
		queue_request(6'd31, 1'b1);
		queue_request(6'd2, 1'b1);
		queue_request(6'd63, 1'b0);
		queue_request(6'd0, 1'b1);
		queue_request(6'd0, 1'b1);
		queue_request(6'd42, 1'b0);
		queue_request(6'd5, 1'b1);
		queue_request(6'd17, 1'b1);
		queue_request(6'd0, 1'b1);
		queue_request(6'd32, 1'b1);
		queue_request(6'd16, 1'b1);
		queue_request(6'd21, 1'b1);
		queue_request(6'd10, 1'b1);
		queue_request(6'd0, 1'b1);
		queue_request(6'd63, 1'b0);
		queue_request(6'd48, 1'b1);
		wait_drained();

		for (int unsigned p = 1; p <= NUM_SETTINGS; p++) begin
			case (p)
				1: begin
					write_reg(CFG_DEVICE_ADDRESS, 10'h000);
					write_reg(CFG_SHORT_TIME, 10'd1);
					write_reg(CFG_LONG_TIME, 10'd1);
				end
				2: begin
					write_reg(CFG_DEVICE_ADDRESS, 10'h3FF);
					write_reg(CFG_SHORT_TIME, 10'd1023);
					write_reg(CFG_LONG_TIME, 10'd1023);
				end
				3: begin
					// Zero pulse lengths give zero-length segments.
					write_reg(CFG_DEVICE_ADDRESS, CFG_DATA_W'($urandom_range(1023)));
					write_reg(CFG_SHORT_TIME, 10'd0);
					write_reg(CFG_LONG_TIME, 10'd0);
					write_reg(CFG_SPARE_INDEX, CFG_DATA_W'($urandom_range(1023)));
				end
				NUM_SETTINGS: begin
					write_reg(CFG_DEVICE_ADDRESS, 10'd114);
					write_reg(CFG_SHORT_TIME, 10'd10);
					write_reg(CFG_LONG_TIME, 10'd180);
				end
				default: begin
					write_reg(CFG_DEVICE_ADDRESS, CFG_DATA_W'($urandom_range(1023)));
					write_reg(CFG_SHORT_TIME, CFG_DATA_W'($urandom_range(1023, 1)));
					write_reg(CFG_LONG_TIME, CFG_DATA_W'($urandom_range(1023, 1)));
					if (p == 6) begin
						write_reg(CFG_SPARE_INDEX, CFG_DATA_W'($urandom_range(1023)));
					end
				end
			endcase

			// Vary the idling per setting; the last setting runs without it.
			if (p == NUM_SETTINGS) begin
				req_gap_pct = 0;
				stall_pct   = 0;
			end else begin
				case (p % 4)
					0: req_gap_pct = 0;
					1: req_gap_pct = 15;
					2: req_gap_pct = 35;
					default: req_gap_pct = 60;
				endcase
				case ((p + 1) % 4)
					0: stall_pct = 0;
					1: stall_pct = 15;
					2: stall_pct = 35;
					default: stall_pct = 60;
				endcase
			end

			repeat (per_setting) queue_random_request();
			wait_drained();
		end

		$display("Checked %0d segments from %0d requests over %0d register settings.",
			segments_checked, requests_taken, NUM_SETTINGS + 1);
		$display("Covered power off, level zero, clamped levels, mode-select preambles.");
		if (error_count == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

	// Watchdog for a hung handshake.
	initial begin
		#2_000_000;
		$display("Run timed out with %0d segments still expected.", seg_expected.size());
		$display("FAILURE");
		$finish;
	end

endmodule
